### rtl/lens_undistort_remap_unit_defines.svh
// ----------------------------------------------------------------------------
// Lens undistortion remap: assertion macros
// Shared assertion wrappers, which can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef LENS_UNDISTORT_REMAP_UNIT_DEFINES_SVH
`define LENS_UNDISTORT_REMAP_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// The antecedent holding at an edge implies the consequent at the same edge.
`define LUR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lens undistort remap: assertion failed");
// The antecedent holding at an edge implies the consequent at the next edge.
`define LUR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lens undistort remap: assertion failed");
`else
`define LUR_ASSERT_IMPL(lbl, ante, cons)
`define LUR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/lur_pkg.sv
// ----------------------------------------------------------------------------
// Lens undistortion remap package
// Payload types, register indexes, reset values and shared helpers.
// ----------------------------------------------------------------------------
package lur_pkg;

    localparam int unsigned DefImgWidth  = 752;
    localparam int unsigned DefImgHeight = 480;

    // Number of quotient bits produced by the normalising divider.
    localparam int unsigned DIV_STEPS = 23;

    typedef struct packed {
        logic [10:0] pixel_col;
        logic [10:0] pixel_row;
    } pix_t;

    typedef struct packed {
        logic [10:0] source_col;
        logic [10:0] source_row;
        logic        inside_res;
    } res_t;

    typedef enum logic [2:0] {
        REG_RADIAL_K1     = 3'd0,
        REG_RADIAL_K2     = 3'd1,
        REG_TANGENTIAL_P1 = 3'd2,
        REG_TANGENTIAL_P2 = 3'd3,
        REG_FOCAL_X       = 3'd4,
        REG_FOCAL_Y       = 3'd5,
        REG_CENTRE_X      = 3'd6,
        REG_CENTRE_Y      = 3'd7
    } cfg_index_t;

    localparam logic signed [31:0] RST_K1 = -32'sd76076785;
    localparam logic signed [31:0] RST_K2 = 32'sd19853236;
    localparam logic signed [31:0] RST_P1 = 32'sd51966;
    localparam logic signed [31:0] RST_P2 = 32'sd4729;
    localparam logic [19:0] RST_FX = 20'd117415;
    localparam logic [19:0] RST_FY = 20'd117068;
    localparam logic [19:0] RST_CX = 20'd94007;
    localparam logic [19:0] RST_CY = 20'd63584;

    localparam logic signed [53:0] LIM_BIG = 54'sd1099511627776;

    // Saturates a wide intermediate to plus or minus two to the fortieth.
    // The result needs 42 bits so that the positive limit stays positive.
    function automatic logic signed [41:0] clamp_big(input logic signed [53:0] v);
        logic signed [53:0] r;
        begin
            if (v > LIM_BIG)
            begin
                r = LIM_BIG;
            end
            else if (v < -LIM_BIG)
            begin
                r = -LIM_BIG;
            end
            else
            begin
                r = v;
            end
            return r[41:0];
        end
    endfunction

endpackage

### rtl/lens_undistort_remap_unit.sv
// ----------------------------------------------------------------------------
// Lens undistortion remap unit
// Maps an undistorted pixel to its source position under a two-radial,
// two-tangential lens model with pinhole intrinsics.
// ----------------------------------------------------------------------------
// The unit accepts one pixel coordinate transaction per clock while the output
// side does not stall and returns one result transaction per input. Throughput
// is one pixel per clock in that case, set by a fully pipelined datapath: a
// 23-stage restoring divider for the normalisation, followed by registered
// multiplier stages for the polynomial and the projection back to pixels. A
// stall on the result side freezes the whole pipeline, so the pixel input is
// stalled only while a finished result is waiting. Configuration registers are
// written through a port that is always ready; they must be written only while
// no pixel is in flight.
`include "lens_undistort_remap_unit_defines.svh"

module lens_undistort_remap_unit #(
    parameter int unsigned IMG_WIDTH  = lur_pkg::DefImgWidth,
    parameter int unsigned IMG_HEIGHT = lur_pkg::DefImgHeight
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pix_valid,
    output logic          pix_stall,
    input  lur_pkg::pix_t pix_data,
    output logic          res_valid,
    input  logic          res_stall,
    output lur_pkg::res_t res_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data
);
    import lur_pkg::*;

    localparam int unsigned NSTG = 42;
    localparam int unsigned LAST = NSTG - 1;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic signed [31:0] k1_reg, k2_reg, p1_reg, p2_reg;
    logic [19:0] fx_reg, fy_reg, cx_reg, cy_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_reg <= RST_K1;
            k2_reg <= RST_K2;
            p1_reg <= RST_P1;
            p2_reg <= RST_P2;
            fx_reg <= RST_FX;
            fy_reg <= RST_FY;
            cx_reg <= RST_CX;
            cy_reg <= RST_CY;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                REG_RADIAL_K1:     k1_reg <= $signed(cfg_data);
                REG_RADIAL_K2:     k2_reg <= $signed(cfg_data);
                REG_TANGENTIAL_P1: p1_reg <= $signed(cfg_data);
                REG_TANGENTIAL_P2: p2_reg <= $signed(cfg_data);
                REG_FOCAL_X:       fx_reg <= cfg_data[19:0];
                REG_FOCAL_Y:       fy_reg <= cfg_data[19:0];
                REG_CENTRE_X:      cx_reg <= cfg_data[19:0];
                REG_CENTRE_Y:      cy_reg <= cfg_data[19:0];
                default:           k1_reg <= k1_reg;
            endcase
        end
    end

    // A zero focal length divides as one 256th of a pixel.
    logic [19:0] fx_div, fy_div;
    assign fx_div = (fx_reg == 20'd0) ? 20'd1 : fx_reg;
    assign fy_div = (fy_reg == 20'd0) ? 20'd1 : fy_reg;

    // ------------------------------------------------------------------
    // Pipeline control. Every stage moves together; valid bits travel
    // alongside the data so bubbles are carried through unchanged.
    // ------------------------------------------------------------------
    logic            en;
    logic [LAST:0]   v_reg;

    assign en        = !v_reg[LAST] || !res_stall;
    assign pix_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[LAST-1:0], pix_valid};
        end
    end

    // Stage 0: capture the pixel.
    logic [10:0] col_reg, row_reg;
    // Stage 1: offset from the principal point in Q.8.
    logic signed [21:0] dx_reg, dy_reg;
    // Stage 2: magnitude and sign of the offset.
    logic [20:0] ax_reg, ay_reg;
    logic        sx_reg, sy_reg;
    // Stage 3: divider set-up with the quotient overflow check.
    logic [43:0] rx0_reg, ry0_reg;
    logic        ox0_reg, oy0_reg, sx0_reg, sy0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col_reg <= pix_data.pixel_col;
            row_reg <= pix_data.pixel_row;

            dx_reg <= $signed({3'b000, col_reg, 8'h00}) - $signed({2'b00, cx_reg});
            dy_reg <= $signed({3'b000, row_reg, 8'h00}) - $signed({2'b00, cy_reg});

            sx_reg <= dx_reg[21];
            sy_reg <= dy_reg[21];
            ax_reg <= dx_reg[21] ? 21'(-dx_reg) : dx_reg[20:0];
            ay_reg <= dy_reg[21] ? 21'(-dy_reg) : dy_reg[20:0];

            // A quotient of two to the 23rd or more saturates anyway.
            ox0_reg <= {7'd0, ax_reg, 16'd0} >= {4'd0, fx_div, 20'd0} << 3;
            oy0_reg <= {7'd0, ay_reg, 16'd0} >= {4'd0, fy_div, 20'd0} << 3;
            rx0_reg <= {7'd0, ax_reg, 16'd0};
            ry0_reg <= {7'd0, ay_reg, 16'd0};
            sx0_reg <= sx_reg;
            sy0_reg <= sy_reg;
        end
    end

    // ------------------------------------------------------------------
    // Restoring divider: one quotient bit per stage, most significant
    // bit first. The overflow flag and sign ride along.
    // ------------------------------------------------------------------
    logic [43:0]          rx_reg [DIV_STEPS];
    logic [43:0]          ry_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] qx_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] qy_reg [DIV_STEPS];
    logic                 ox_reg [DIV_STEPS];
    logic                 oy_reg [DIV_STEPS];
    logic                 sxd_reg [DIV_STEPS];
    logic                 syd_reg [DIV_STEPS];

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        localparam int unsigned BIT = DIV_STEPS - 1 - i;
        logic [43:0]          rx_in, ry_in, tx_sub, ty_sub;
        logic [DIV_STEPS-1:0] qx_in, qy_in;
        logic                 ox_in, oy_in, sx_in, sy_in;

        if (i == 0)
        begin : g_first
            assign rx_in = rx0_reg;
            assign ry_in = ry0_reg;
            assign qx_in = '0;
            assign qy_in = '0;
            assign ox_in = ox0_reg;
            assign oy_in = oy0_reg;
            assign sx_in = sx0_reg;
            assign sy_in = sy0_reg;
        end
        else
        begin : g_next
            assign rx_in = rx_reg[i-1];
            assign ry_in = ry_reg[i-1];
            assign qx_in = qx_reg[i-1];
            assign qy_in = qy_reg[i-1];
            assign ox_in = ox_reg[i-1];
            assign oy_in = oy_reg[i-1];
            assign sx_in = sxd_reg[i-1];
            assign sy_in = syd_reg[i-1];
        end

        assign tx_sub = {24'd0, fx_div} << BIT;
        assign ty_sub = {24'd0, fy_div} << BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rx_reg[i]  <= (rx_in >= tx_sub) ? rx_in - tx_sub : rx_in;
                ry_reg[i]  <= (ry_in >= ty_sub) ? ry_in - ty_sub : ry_in;
                qx_reg[i]  <= {qx_in[DIV_STEPS-2:0], rx_in >= tx_sub};
                qy_reg[i]  <= {qy_in[DIV_STEPS-2:0], ry_in >= ty_sub};
                ox_reg[i]  <= ox_in;
                oy_reg[i]  <= oy_in;
                sxd_reg[i] <= sx_in;
                syd_reg[i] <= sy_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // Normalised coordinates, distortion polynomial and projection.
    // ------------------------------------------------------------------
    localparam logic [DIV_STEPS-1:0] LIM_XY = 23'd4194304;

    logic [DIV_STEPS-1:0] mx, my;
    assign mx = (ox_reg[DIV_STEPS-1] || qx_reg[DIV_STEPS-1] > LIM_XY)
              ? LIM_XY : qx_reg[DIV_STEPS-1];
    assign my = (oy_reg[DIV_STEPS-1] || qy_reg[DIV_STEPS-1] > LIM_XY)
              ? LIM_XY : qy_reg[DIV_STEPS-1];

    logic signed [23:0] x_reg, y_reg, x28_reg, y28_reg, x29_reg, y29_reg;
    logic signed [23:0] x30_reg, y30_reg, x31_reg, y31_reg, x32_reg, y32_reg;
    logic signed [23:0] x33_reg, y33_reg;
    logic signed [47:0] pxx_reg, pyy_reg, pxy_reg;
    logic signed [31:0] x2_reg, y2_reg, xy_reg, r2_reg;
    logic signed [31:0] xy30_reg, r230_reg, tax_reg, tay_reg;
    logic signed [63:0] k1r2_reg, k2r2_reg;
    logic signed [35:0] k1s_reg;
    logic signed [67:0] m2_reg;
    logic signed [63:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [53:0] fac_raw_reg;
    logic signed [37:0] tanx_reg, tany_reg, tanx33_reg, tany33_reg;
    logic signed [37:0] tanx34_reg, tany34_reg, tanx35_reg, tany35_reg;
    logic signed [41:0] fac_reg;
    logic signed [47:0] xlo_reg, xhi_reg, ylo_reg, yhi_reg;
    logic signed [67:0] xs_reg, ys_reg;
    logic signed [53:0] xdp_reg, ydp_reg;
    logic signed [41:0] xd_reg, yd_reg;
    logic signed [43:0] ulo_reg, uhi_reg, vlo_reg, vhi_reg;
    logic signed [65:0] us_reg, vs_reg;
    logic signed [51:0] ud_reg, vd_reg;
    res_t               res_reg;

    logic in_frame;
    assign in_frame = !ud_reg[51] && !vd_reg[51]
                   && ({1'b0, ud_reg[50:8]} < 44'(IMG_WIDTH))
                   && ({1'b0, vd_reg[50:8]} < 44'(IMG_HEIGHT));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Signed normalised coordinates, Q.16.
            x_reg <= sxd_reg[DIV_STEPS-1] ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
            y_reg <= syd_reg[DIV_STEPS-1] ? -$signed({1'b0, my}) : $signed({1'b0, my});

            pxx_reg <= x_reg * x_reg;
            pyy_reg <= y_reg * y_reg;
            pxy_reg <= x_reg * y_reg;
            x28_reg <= x_reg;
            y28_reg <= y_reg;

            x2_reg  <= pxx_reg[47:16];
            y2_reg  <= pyy_reg[47:16];
            xy_reg  <= pxy_reg[47:16];
            r2_reg  <= $signed(pxx_reg[47:16]) + $signed(pyy_reg[47:16]);
            x29_reg <= x28_reg;
            y29_reg <= y28_reg;

            k1r2_reg <= k1_reg * r2_reg;
            k2r2_reg <= k2_reg * r2_reg;
            tax_reg  <= r2_reg + (x2_reg <<< 1);
            tay_reg  <= r2_reg + (y2_reg <<< 1);
            xy30_reg <= xy_reg;
            r230_reg <= r2_reg;
            x30_reg  <= x29_reg;
            y30_reg  <= y29_reg;

            k1s_reg <= $signed(k1r2_reg[63:28]);
            m2_reg  <= $signed(k2r2_reg[63:28]) * r230_reg;
            pa_reg  <= p1_reg * xy30_reg;
            pb_reg  <= p2_reg * tax_reg;
            pc_reg  <= p1_reg * tay_reg;
            pd_reg  <= p2_reg * xy30_reg;
            x31_reg <= x30_reg;
            y31_reg <= y30_reg;

            // Doubling before the shift by 28 equals a shift by 27.
            fac_raw_reg <= 54'sd65536 + k1s_reg + $signed(m2_reg[67:16]);
            tanx_reg <= $signed(pa_reg[63:27]) + $signed(pb_reg[63:28]);
            tany_reg <= $signed(pc_reg[63:28]) + $signed(pd_reg[63:27]);
            x32_reg  <= x31_reg;
            y32_reg  <= y31_reg;

            fac_reg    <= clamp_big(fac_raw_reg);
            tanx33_reg <= tanx_reg;
            tany33_reg <= tany_reg;
            x33_reg    <= x32_reg;
            y33_reg    <= y32_reg;

            // The wide factor is split into two partial products.
            xlo_reg <= x33_reg * $signed({1'b0, fac_reg[19:0]});
            xhi_reg <= x33_reg * $signed(fac_reg[41:20]);
            ylo_reg <= y33_reg * $signed({1'b0, fac_reg[19:0]});
            yhi_reg <= y33_reg * $signed(fac_reg[41:20]);
            tanx34_reg <= tanx33_reg;
            tany34_reg <= tany33_reg;

            xs_reg <= (68'(xhi_reg) <<< 20) + 68'(xlo_reg);
            ys_reg <= (68'(yhi_reg) <<< 20) + 68'(ylo_reg);
            tanx35_reg <= tanx34_reg;
            tany35_reg <= tany34_reg;

            xdp_reg <= $signed(xs_reg[67:16]) + tanx35_reg;
            ydp_reg <= $signed(ys_reg[67:16]) + tany35_reg;

            xd_reg <= clamp_big(xdp_reg);
            yd_reg <= clamp_big(ydp_reg);

            ulo_reg <= $signed({1'b0, fx_reg}) * $signed({1'b0, xd_reg[19:0]});
            uhi_reg <= $signed({1'b0, fx_reg}) * $signed(xd_reg[41:20]);
            vlo_reg <= $signed({1'b0, fy_reg}) * $signed({1'b0, yd_reg[19:0]});
            vhi_reg <= $signed({1'b0, fy_reg}) * $signed(yd_reg[41:20]);

            us_reg <= (66'(uhi_reg) <<< 20) + 66'(ulo_reg);
            vs_reg <= (66'(vhi_reg) <<< 20) + 66'(vlo_reg);

            ud_reg <= $signed(us_reg[65:16]) + $signed({1'b0, cx_reg});
            vd_reg <= $signed(vs_reg[65:16]) + $signed({1'b0, cy_reg});

            // Points that fall outside the frame are zero filled.
            res_reg.inside_res <= in_frame;
            res_reg.source_col <= in_frame ? ud_reg[18:8] : 11'd0;
            res_reg.source_row <= in_frame ? vd_reg[18:8] : 11'd0;
        end
    end

    assign res_valid = v_reg[LAST];
    assign res_data  = res_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `LUR_ASSERT_IMPL(a_stall_only_when_full, pix_stall, res_valid && res_stall)
    `LUR_ASSERT_NEXT(a_accept_enters, pix_valid && !pix_stall, v_reg[0])
    `LUR_ASSERT_IMPL(a_outside_zero, res_valid && !res_data.inside_res,
        res_data.source_col == 11'd0 && res_data.source_row == 11'd0)

endmodule
